[hw/rtl/gcd_pkg.sv]
// gcd_pkg: constants and tables shared by the great-circle distance pipeline.
// No dependencies; imported by gcd_isqrt and great_circle_distance_top.
package gcd_pkg;

   // CORDIC depth, one rotation per pipeline stage (valid range 12 to 32)
   localparam int CORDIC_STAGES = 24;

   // total register stages between input acceptance and the result register
   localparam int PIPE_DEPTH = 2 * CORDIC_STAGES + 74;

   localparam logic [32:0] CORDIC_GAIN = 33'd652032874;   // 1/K in Q30
   localparam logic [30:0] PI_Q29      = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;

   localparam logic [23:0] RADIUS_RESET = 24'd1013443;
   localparam logic [21:0] DISTANCE_MAX = 22'h3F_FFFF;

   // register index carried in paddr[2] (byte address 4*i)
   localparam logic CSR_RADIUS = 1'b0;

   // mag / 45 as (mag * DIV45_MUL) >> 31, exact for 25-bit magnitudes
   localparam logic [25:0] DIV45_MUL = 26'd47721859;

   // floor((r * 65536 + 180) / 360) for r = mag mod 45
   localparam logic [12:0] BAM_FRAC [64] = '{
      13'd0,    13'd182,  13'd364,  13'd546,  13'd728,  13'd910,  13'd1092, 13'd1274,
      13'd1456, 13'd1638, 13'd1820, 13'd2002, 13'd2185, 13'd2367, 13'd2549, 13'd2731,
      13'd2913, 13'd3095, 13'd3277, 13'd3459, 13'd3641, 13'd3823, 13'd4005, 13'd4187,
      13'd4369, 13'd4551, 13'd4733, 13'd4915, 13'd5097, 13'd5279, 13'd5461, 13'd5643,
      13'd5825, 13'd6007, 13'd6190, 13'd6372, 13'd6554, 13'd6736, 13'd6918, 13'd7100,
      13'd7282, 13'd7464, 13'd7646, 13'd7828, 13'd8010, 13'd0,    13'd0,    13'd0,
      13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,
      13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0
   };

   // atan(2^-i) in binary angle units (2^32 per turn)
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // integer square root unit
   localparam int SQRT_RAD_W  = 64;
   localparam int SQRT_ROOT_W = 32;
   localparam int SQRT_REM_W  = 35;

endpackage

[hw/rtl/great_circle_distance_top.sv]
// great_circle_distance_top: chord-formula great-circle distance pipeline.
// Depends on gcd_pkg and gcd_isqrt.

// Takes one point pair per cycle and returns one distance word per pair, in
// order. Every step is its own register stage: degree to binary angle
// conversion (2), four sin/cos CORDIC lanes (one rotation per stage), quadrant
// fixup, the Q30 products, squares, sum, a 32-stage square root for the half
// chord, clamp and square, a second 32-stage square root, a vectoring CORDIC
// for the angle, then two multiplies for radians and radius. The whole pipe
// moves together: req_ready drops only while a result sits in the output
// register and rsp_ready is low, so throughput is one word per cycle. Angles
// wrap modulo 360 degrees, a half chord above one is clamped, and the distance
// saturates at 4194303. sphere_radius (1/256 mile, address 0) must be written
// only while the pipe is empty.
module great_circle_distance_top
   import gcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_source_latitude,
   input  logic signed [24:0] req_source_longitude,
   input  logic signed [23:0] req_dest_latitude,
   input  logic signed [24:0] req_dest_longitude,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [21:0]        rsp_distance,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int N = CORDIC_STAGES;
   localparam int H_STAGE = N + 38;   // valid bit index of the clamped half chord

   // ---------------- control ----------------
   logic                  adv;            // whole pipe advances
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;
   logic [21:0]           rsp_distance_ff;
   logic [23:0]           radius_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_RADIUS) ? {8'h00, radius_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == CSR_RADIUS) begin
         radius_ff <= csr_pwdata[23:0];
      end
   end

   // ---------------- angle lanes: src lat, src lon, dst lat, dst lon ----------------
   logic signed [24:0] lane_in [4];
   assign lane_in[0] = 25'(req_source_latitude);
   assign lane_in[1] = req_source_longitude;
   assign lane_in[2] = 25'(req_dest_latitude);
   assign lane_in[3] = req_dest_longitude;

   logic               neg_ff  [4];
   logic [24:0]        mag_ff  [4];
   logic [50:0]        prod_ff [4];
   logic [31:0]        bam_ff  [4];
   logic signed [32:0] cx_ff   [4][N];
   logic signed [32:0] cy_ff   [4][N];
   logic signed [31:0] cz_ff   [4][N];
   logic [1:0]         ck_ff   [4][N];
   logic signed [32:0] cos_ff  [4];
   logic signed [32:0] sin_ff  [4];

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [24:0] mag;
      logic [18:0] quo;
      logic [24:0] quo45;
      logic [5:0]  rem45;
      logic [31:0] q;

      assign mag = lane_in[l][24] ? 25'(-lane_in[l]) : 25'(lane_in[l]);

      // stage 1: magnitude times reciprocal of 45
      always_ff @(posedge clock) begin
         if (adv) begin
            neg_ff[l]  <= lane_in[l][24];
            mag_ff[l]  <= mag;
            prod_ff[l] <= 51'(mag) * 51'(DIV45_MUL);
         end
      end

      // stage 2: bam = (mag/45)*8192 + round(rem*65536/360), sign restored
      assign quo   = prod_ff[l][49:31];
      assign quo45 = 25'(quo) * 25'd45;
      assign rem45 = 6'(mag_ff[l] - quo45);
      assign q     = {quo, 13'b0} | 32'(BAM_FRAC[rem45]);

      always_ff @(posedge clock) begin
         if (adv) begin
            bam_ff[l] <= neg_ff[l] ? 32'(-q) : q;
         end
      end

      // rotation CORDIC after folding into the nearest quadrant
      for (genvar j = 0; j < N; j++) begin : g_rot
         logic signed [32:0] px, py;
         logic signed [31:0] pz;
         logic [1:0]         pk;

         if (j == 0) begin : g_fold
            logic [31:0] bam_plus;
            assign bam_plus = bam_ff[l] + 32'h2000_0000;
            assign pk = bam_plus[31:30];
            assign pz = $signed(bam_ff[l] - {pk, 30'b0});
            assign px = $signed(CORDIC_GAIN);
            assign py = '0;
         end else begin : g_chain
            assign px = cx_ff[l][j-1];
            assign py = cy_ff[l][j-1];
            assign pz = cz_ff[l][j-1];
            assign pk = ck_ff[l][j-1];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               ck_ff[l][j] <= pk;
               if (!pz[31]) begin
                  cx_ff[l][j] <= px - (py >>> j);
                  cy_ff[l][j] <= py + (px >>> j);
                  cz_ff[l][j] <= pz - $signed(ATAN_TABLE[j]);
               end else begin
                  cx_ff[l][j] <= px + (py >>> j);
                  cy_ff[l][j] <= py - (px >>> j);
                  cz_ff[l][j] <= pz + $signed(ATAN_TABLE[j]);
               end
            end
         end
      end

      // quadrant fixup
      always_ff @(posedge clock) begin
         if (adv) begin
            case (ck_ff[l][N-1])
               2'd0: begin
                  cos_ff[l] <= cx_ff[l][N-1];
                  sin_ff[l] <= cy_ff[l][N-1];
               end
               2'd1: begin
                  cos_ff[l] <= -cy_ff[l][N-1];
                  sin_ff[l] <= cx_ff[l][N-1];
               end
               2'd2: begin
                  cos_ff[l] <= -cx_ff[l][N-1];
                  sin_ff[l] <= -cy_ff[l][N-1];
               end
               default: begin
                  cos_ff[l] <= cy_ff[l][N-1];
                  sin_ff[l] <= -cx_ff[l][N-1];
               end
            endcase
         end
      end
   end

   // ---------------- cartesian products (Q30, rounded) ----------------
   logic signed [65:0] m_a, m_b, m_c, m_d;
   logic signed [32:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [33:0] dz_ff;

   assign m_a = 66'(cos_ff[2]) * 66'(cos_ff[3]) + 66'sd536870912;
   assign m_b = 66'(cos_ff[0]) * 66'(cos_ff[1]) + 66'sd536870912;
   assign m_c = 66'(cos_ff[2]) * 66'(sin_ff[3]) + 66'sd536870912;
   assign m_d = 66'(cos_ff[0]) * 66'(sin_ff[1]) + 66'sd536870912;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff <= 33'(m_a >>> 30);
         pb_ff <= 33'(m_b >>> 30);
         pc_ff <= 33'(m_c >>> 30);
         pd_ff <= 33'(m_d >>> 30);
         dz_ff <= 34'(sin_ff[2]) - 34'(sin_ff[0]);
      end
   end

   // ---------------- chord squared ----------------
   logic signed [33:0] dx, dy;
   logic [63:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [63:0]        sum_ff;

   assign dx = 34'(pa_ff) - 34'(pb_ff);
   assign dy = 34'(pc_ff) - 34'(pd_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= 64'(68'(dx) * 68'(dx));
         sqy_ff <= 64'(68'(dy) * 68'(dy));
         sqz_ff <= 64'(68'(dz_ff) * 68'(dz_ff));
      end
   end

   // quarter of the chord squared, so its root is the half chord
   logic [63:0] sum_all;
   assign sum_all = sqx_ff + sqy_ff + sqz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= {2'b00, sum_all[63:2]};
      end
   end

   // ---------------- half chord and its cosine partner ----------------
   logic [31:0] h_root;
   logic [30:0] h_ff, h2_ff;
   logic [61:0] hsq_ff;
   logic [63:0] w_rad;
   logic [31:0] w_root;
   logic [30:0] hd_ff [SQRT_ROOT_W];

   gcd_isqrt u_sqrt_h (
      .clock    (clock),
      .en       (adv),
      .radicand (sum_ff),
      .root     (h_root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff   <= (h_root > 32'(ONE_Q30)) ? ONE_Q30 : h_root[30:0];
         h2_ff  <= h_ff;
         hsq_ff <= 62'(h_ff) * 62'(h_ff);
      end
   end

   assign w_rad = 64'h1000_0000_0000_0000 - 64'(hsq_ff);

   gcd_isqrt u_sqrt_w (
      .clock    (clock),
      .en       (adv),
      .radicand (w_rad),
      .root     (w_root)
   );

   // keep h aligned with the second root
   for (genvar i = 0; i < SQRT_ROOT_W; i++) begin : g_hdly
      always_ff @(posedge clock) begin
         if (adv) begin
            hd_ff[i] <= (i == 0) ? h2_ff : hd_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // ---------------- vectoring CORDIC: angle of (w, h) ----------------
   logic signed [33:0] vx_ff [N];
   logic signed [33:0] vy_ff [N];
   logic signed [32:0] vz_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_vec
      logic signed [33:0] px, py;
      logic signed [32:0] pz;

      if (j == 0) begin : g_head
         assign px = $signed(34'(w_root));
         assign py = $signed(34'(hd_ff[SQRT_ROOT_W-1]));
         assign pz = '0;
      end else begin : g_chain
         assign px = vx_ff[j-1];
         assign py = vy_ff[j-1];
         assign pz = vz_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (!py[33] && py != '0) begin
               vx_ff[j] <= px + (py >>> j);
               vy_ff[j] <= py - (px >>> j);
               vz_ff[j] <= pz + $signed(33'(ATAN_TABLE[j]));
            end else begin
               vx_ff[j] <= px - (py >>> j);
               vy_ff[j] <= py + (px >>> j);
               vz_ff[j] <= pz - $signed(33'(ATAN_TABLE[j]));
            end
         end
      end
   end

   // ---------------- angle in radians, then distance ----------------
   logic [31:0] zc;
   logic [63:0] ang_full;
   logic [31:0] ang_ff;
   logic [55:0] dist_full;
   logic [25:0] dist_ff;
   logic [21:0] dist_sat;

   // small negative angle for coincident points reads as zero
   assign zc       = vz_ff[N-1][32] ? 32'h0 : vz_ff[N-1][31:0];
   assign ang_full = 64'(zc) * 64'(PI_Q29) + 64'h1000_0000;

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff <= ang_full[60:29];
      end
   end

   assign dist_full = 56'(ang_ff) * 56'(radius_ff) + 56'h2000_0000;

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_full[55:30];
      end
   end

   assign dist_sat = (dist_ff > 26'(DISTANCE_MAX)) ? DISTANCE_MAX : dist_ff[21:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_distance_ff <= dist_sat;
      end
   end

`ifndef ASSERT_OFF
   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid chain moved during a stall");

   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_RADIUS
      |=> radius_ff == $past(csr_pwdata[23:0]))
      else $error("radius write lost");

   a_half_chord_clamped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[H_STAGE] |-> h_ff <= ONE_Q30)
      else $error("half chord above one");
`endif

endmodule

[hw/rtl/gcd_isqrt.sv]
// gcd_isqrt: pipelined floor square root, one result bit per stage.
// Depends on gcd_pkg for the radicand, root and remainder widths.
module gcd_isqrt
   import gcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [SQRT_RAD_W-1:0]  radicand,
   output logic [SQRT_ROOT_W-1:0] root
);

   logic [SQRT_REM_W-1:0]  rem_ff  [SQRT_ROOT_W];
   logic [SQRT_ROOT_W-1:0] root_ff [SQRT_ROOT_W];
   logic [SQRT_RAD_W-1:0]  rad_ff  [SQRT_ROOT_W];

   for (genvar i = 0; i < SQRT_ROOT_W; i++) begin : g_step
      logic [SQRT_REM_W-1:0]  prem;
      logic [SQRT_ROOT_W-1:0] proot;
      logic [SQRT_RAD_W-1:0]  prad;
      logic [SQRT_REM_W-1:0]  acc_in;
      logic [SQRT_REM_W-1:0]  trial;

      if (i == 0) begin : g_head
         assign prem  = '0;
         assign proot = '0;
         assign prad  = radicand;
      end else begin : g_body
         assign prem  = rem_ff[i-1];
         assign proot = root_ff[i-1];
         assign prad  = rad_ff[i-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign acc_in = {prem[SQRT_REM_W-3:0], prad[SQRT_RAD_W-1 -: 2]};
      assign trial  = SQRT_REM_W'({proot, 2'b01});

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i] <= {prad[SQRT_RAD_W-3:0], 2'b00};
            if (acc_in >= trial) begin
               rem_ff[i]  <= acc_in - trial;
               root_ff[i] <= {proot[SQRT_ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= acc_in;
               root_ff[i] <= {proot[SQRT_ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[SQRT_ROOT_W-1];

endmodule
